// ===== rtl/core/kvd_pkg.sv =====
// Shared types and constants of the key-value binary response deframer.
// Depends on nothing; every other file of the block except kvd_if refers to it by scoped names.
`default_nettype none

package kvd_pkg;

  // Header layout.
  localparam int unsigned HEADER_BYTES = 24;
  localparam int unsigned HDR_IDX_W    = 5;
  localparam logic [HDR_IDX_W-1:0] HDR_LAST = HDR_IDX_W'(HEADER_BYTES - 1);

  // Header byte positions that carry fields.
  localparam logic [HDR_IDX_W-1:0] HB_MAGIC     = 5'd0;
  localparam logic [HDR_IDX_W-1:0] HB_KEY_HI    = 5'd2;
  localparam logic [HDR_IDX_W-1:0] HB_KEY_LO    = 5'd3;
  localparam logic [HDR_IDX_W-1:0] HB_EXTRAS    = 5'd4;
  localparam logic [HDR_IDX_W-1:0] HB_STATUS_HI = 5'd6;
  localparam logic [HDR_IDX_W-1:0] HB_STATUS_LO = 5'd7;
  localparam logic [HDR_IDX_W-1:0] HB_BODY_0    = 5'd8;
  localparam logic [HDR_IDX_W-1:0] HB_BODY_1    = 5'd9;
  localparam logic [HDR_IDX_W-1:0] HB_BODY_2    = 5'd10;
  localparam logic [HDR_IDX_W-1:0] HB_BODY_3    = 5'd11;

  // Input action codes.
  localparam logic ACT_BYTE    = 1'b0;
  localparam logic ACT_RESTART = 1'b1;

  // Result kinds.
  localparam logic [2:0] KIND_HEADER = 3'd0;
  localparam logic [2:0] KIND_EXTRAS = 3'd1;
  localparam logic [2:0] KIND_KEY    = 3'd2;
  localparam logic [2:0] KIND_VALUE  = 3'd3;
  localparam logic [2:0] KIND_ERROR  = 3'd4;

  localparam logic [7:0] MAGIC_RESET = 8'd129;

  // One result as the parser hands it to the queue, before formatting.
  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  payload_byte;
    logic [15:0] status_word;
    logic [7:0]  extras_len;
    logic [15:0] key_len;
    logic [31:0] body_len;
    logic        last;
  } kvd_rec_t;

endpackage

`default_nettype wire

// ===== rtl/core/kvd_if.sv =====
// Channel interfaces of the deframer: received bytes, results and the
// configuration write channel. Depends on nothing.
`default_nettype none

interface kvd_byte_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] data_byte;
  modport source(output valid, action, data_byte, input ready);
  modport sink(input valid, action, data_byte, output ready);
endinterface

interface kvd_res_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [7:0]  payload_byte;
  logic [15:0] status_code;
  logic [7:0]  extras_count;
  logic [15:0] key_count;
  logic [31:0] value_count;
  logic        last;
  modport source(output valid, kind, payload_byte, status_code, extras_count, key_count,
                 value_count, last, input ready);
  modport sink(input valid, kind, payload_byte, status_code, extras_count, key_count,
               value_count, last, output ready);
endinterface

interface kvd_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;
  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/kvd_front.sv =====
// Front end of the deframer: accepts bytes, tracks the header and body
// parts and pushes one raw result record per result. Uses kvd_pkg, kvd_if.
`default_nettype none

module kvd_front (
  input  wire logic              clk,
  input  wire logic              rst,
  kvd_byte_if.sink               rx,
  input  wire logic [7:0]        response_magic,
  input  wire logic              q_space,
  output logic                   q_push,
  output kvd_pkg::kvd_rec_t      q_rec
);

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_EXTRAS,
    PH_KEY,
    PH_VALUE,
    PH_HALT
  } phase_t;

  phase_t                          phase, phase_next;
  logic [kvd_pkg::HDR_IDX_W-1:0]   header_index, header_index_next;
  logic [7:0]                      magic_seen, magic_seen_next;
  logic [15:0]                     status_word, status_word_next;
  logic [15:0]                     key_len, key_len_next;
  logic [7:0]                      extras_len, extras_len_next;
  logic [31:0]                     body_left, body_left_next;
  logic [15:0]                     part_left, part_left_next;

  logic        accept;
  logic [16:0] hdr_sum;
  logic        hdr_bad;
  logic [31:0] body_dec;
  logic [15:0] part_dec;

  assign rx.ready = q_space;
  assign accept   = rx.valid && q_space;
  assign hdr_sum  = {1'b0, key_len} + {9'b0, extras_len};
  assign hdr_bad  = (magic_seen != response_magic) || ({15'b0, hdr_sum} > body_left);
  assign body_dec = (body_left != 32'd0) ? body_left - 32'd1 : body_left;
  assign part_dec = (part_left != 16'd0) ? part_left - 16'd1 : part_left;

  always_comb begin
    phase_next        = phase;
    header_index_next = header_index;
    magic_seen_next   = magic_seen;
    status_word_next  = status_word;
    key_len_next      = key_len;
    extras_len_next   = extras_len;
    body_left_next    = body_left;
    part_left_next    = part_left;
    q_push            = 1'b0;
    q_rec.kind         = kvd_pkg::KIND_HEADER;
    q_rec.payload_byte = rx.data_byte;
    q_rec.status_word  = status_word;
    q_rec.extras_len   = extras_len;
    q_rec.key_len      = key_len;
    q_rec.body_len     = body_left;
    q_rec.last         = 1'b0;

    if (accept) begin
      if (rx.action == kvd_pkg::ACT_RESTART) begin
        phase_next        = PH_HEADER;
        header_index_next = '0;
      end else begin
        case (phase)
          PH_HEADER: begin
            case (header_index)
              kvd_pkg::HB_MAGIC:     magic_seen_next  = rx.data_byte;
              kvd_pkg::HB_KEY_HI:    key_len_next     = {rx.data_byte, 8'h00};
              kvd_pkg::HB_KEY_LO:    key_len_next     = {key_len[15:8], rx.data_byte};
              kvd_pkg::HB_EXTRAS:    extras_len_next  = rx.data_byte;
              kvd_pkg::HB_STATUS_HI: status_word_next = {rx.data_byte, 8'h00};
              kvd_pkg::HB_STATUS_LO: status_word_next = {status_word[15:8], rx.data_byte};
              kvd_pkg::HB_BODY_0:    body_left_next   = {24'b0, rx.data_byte};
              kvd_pkg::HB_BODY_1, kvd_pkg::HB_BODY_2, kvd_pkg::HB_BODY_3: begin
                body_left_next = {body_left[23:0], rx.data_byte};
              end
              default: ;
            endcase
            if (header_index != kvd_pkg::HDR_LAST) begin
              header_index_next = header_index + 1'b1;
            end else begin
              header_index_next = '0;
              q_push            = 1'b1;
              if (hdr_bad) begin
                phase_next = PH_HALT;
                q_rec.kind = kvd_pkg::KIND_ERROR;
                q_rec.last = 1'b1;
              end else begin
                q_rec.kind = kvd_pkg::KIND_HEADER;
                q_rec.last = (body_left == 32'd0);
                if (extras_len != 8'd0) begin
                  phase_next     = PH_EXTRAS;
                  part_left_next = {8'b0, extras_len};
                end else if (key_len != 16'd0) begin
                  phase_next     = PH_KEY;
                  part_left_next = key_len;
                end else if (body_left != 32'd0) begin
                  phase_next     = PH_VALUE;
                  part_left_next = '0;
                end else begin
                  phase_next     = PH_HEADER;
                  part_left_next = '0;
                end
              end
            end
          end
          PH_EXTRAS, PH_KEY, PH_VALUE: begin
            q_push         = 1'b1;
            q_rec.last     = (body_dec == 32'd0);
            body_left_next = body_dec;
            case (phase)
              PH_EXTRAS: q_rec.kind = kvd_pkg::KIND_EXTRAS;
              PH_KEY:    q_rec.kind = kvd_pkg::KIND_KEY;
              default:   q_rec.kind = kvd_pkg::KIND_VALUE;
            endcase
            if (phase == PH_VALUE) begin
              if (body_dec == 32'd0) begin
                phase_next        = PH_HEADER;
                header_index_next = '0;
              end
            end else begin
              part_left_next = part_dec;
              if (part_dec == 16'd0) begin
                // The current part is used up: move on to the next nonempty one.
                if (phase == PH_EXTRAS && key_len != 16'd0) begin
                  phase_next     = PH_KEY;
                  part_left_next = key_len;
                end else if (body_dec != 32'd0) begin
                  phase_next     = PH_VALUE;
                  part_left_next = '0;
                end else begin
                  phase_next        = PH_HEADER;
                  header_index_next = '0;
                  part_left_next    = '0;
                end
              end
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HEADER;
      header_index <= '0;
      magic_seen   <= '0;
      status_word  <= '0;
      key_len      <= '0;
      extras_len   <= '0;
      body_left    <= '0;
      part_left    <= '0;
    end else begin
      phase        <= phase_next;
      header_index <= header_index_next;
      magic_seen   <= magic_seen_next;
      status_word  <= status_word_next;
      key_len      <= key_len_next;
      extras_len   <= extras_len_next;
      body_left    <= body_left_next;
      part_left    <= part_left_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/kvd_queue.sv =====
// Small first-in first-out queue of raw result records between the parser
// and the output stage. Uses kvd_pkg.
`default_nettype none

module kvd_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire kvd_pkg::kvd_rec_t wr_rec,
  output logic                   space,
  input  wire logic              pop,
  output logic                   rd_valid,
  output kvd_pkg::kvd_rec_t      rd_rec
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  kvd_pkg::kvd_rec_t mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr, rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              do_push, do_pop;

  assign space    = (count != CNT_FULL);
  assign rd_valid = (count != '0);
  assign rd_rec   = mem[rd_ptr];
  assign do_push  = push && space;
  assign do_pop   = pop && rd_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/kvd_back.sv =====
// Output stage of the deframer: takes raw records from the queue, works out
// the value length, clears unused fields and holds the result register.
// Uses kvd_pkg and kvd_if.
`default_nettype none

module kvd_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              q_valid,
  input  wire kvd_pkg::kvd_rec_t q_rec,
  output logic                   q_pop,
  kvd_res_if.source              tx
);

  logic        out_valid;
  logic [2:0]  kind;
  logic [7:0]  payload_byte;
  logic [15:0] status_code;
  logic [7:0]  extras_count;
  logic [15:0] key_count;
  logic [31:0] value_count;
  logic        last;

  logic [7:0]  payload_next;
  logic [15:0] status_next;
  logic [7:0]  extras_next;
  logic [15:0] key_next;
  logic [31:0] value_next;

  assign q_pop = q_valid && (!out_valid || tx.ready);

  always_comb begin
    payload_next = '0;
    status_next  = '0;
    extras_next  = '0;
    key_next     = '0;
    value_next   = '0;
    case (q_rec.kind)
      kvd_pkg::KIND_HEADER: begin
        status_next = q_rec.status_word;
        extras_next = q_rec.extras_len;
        key_next    = q_rec.key_len;
        value_next  = q_rec.body_len - {24'b0, q_rec.extras_len} - {16'b0, q_rec.key_len};
      end
      kvd_pkg::KIND_EXTRAS, kvd_pkg::KIND_KEY, kvd_pkg::KIND_VALUE: begin
        payload_next = q_rec.payload_byte;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop) begin
      out_valid <= 1'b1;
    end else if (tx.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      kind         <= q_rec.kind;
      payload_byte <= payload_next;
      status_code  <= status_next;
      extras_count <= extras_next;
      key_count    <= key_next;
      value_count  <= value_next;
      last         <= q_rec.last;
    end
  end

  assign tx.valid        = out_valid;
  assign tx.kind         = kind;
  assign tx.payload_byte = payload_byte;
  assign tx.status_code  = status_code;
  assign tx.extras_count = extras_count;
  assign tx.key_count    = key_count;
  assign tx.value_count  = value_count;
  assign tx.last         = last;

endmodule

`default_nettype wire

// ===== rtl/core/kv_binary_response_deframer_top.sv =====
// Top level of the key-value binary response deframer.
// Depends on kvd_pkg, kvd_if, kvd_front, kvd_queue and kvd_back.
//
// Usage:
// The rx channel carries one beat per received response byte (action 0) or a
// restart request (action 1) that returns the parser to the start of a header.
// The tx channel carries results: one header-info beat after the 24th header
// byte, then one beat per extras, key and value byte, with last set on the
// final beat of the response. A bad magic or a key plus extras length larger
// than the body gives a single protocol-error beat and the block then drops
// bytes until a restart. The cfg channel writes the expected magic byte; it is
// always ready and is meant to be written only while the block is idle.
// Throughput is one rx beat per cycle while the queue has space. The rx beat
// writes its record into the queue, from where the record moves into the
// output register, from which tx takes the result. At reset the magic returns
// to 129, the parser waits for the first header byte and the queue is empty.
// When the receiver stalls, up to QUEUE_DEPTH results collect in the queue
// plus one in the output register; only then does rx.ready drop, and it rises
// again as soon as a slot frees up.

`default_nettype none

module kv_binary_response_deframer_top #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire logic  clk,
  input  wire logic  rst,
  kvd_cfg_if.sink    cfg,
  kvd_byte_if.sink   rx,
  kvd_res_if.source  tx
);

  logic [7:0]        response_magic;
  logic              q_push;
  logic              q_space;
  logic              q_valid;
  logic              q_pop;
  kvd_pkg::kvd_rec_t push_rec;
  kvd_pkg::kvd_rec_t head_rec;

  // Expected magic byte; written by the configuration channel.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      response_magic <= kvd_pkg::MAGIC_RESET;
    end else if (cfg.valid) begin
      response_magic <= cfg.data;
    end
  end

  // Parser: classifies each byte and produces at most one raw record per beat.
  kvd_front u_front (
    .clk            (clk),
    .rst            (rst),
    .rx             (rx),
    .response_magic (response_magic),
    .q_space        (q_space),
    .q_push         (q_push),
    .q_rec          (push_rec)
  );

  // The queue lets the parser keep taking bytes while the receiver stalls.
  kvd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .wr_rec   (push_rec),
    .space    (q_space),
    .pop      (q_pop),
    .rd_valid (q_valid),
    .rd_rec   (head_rec)
  );

  // Output stage: formats each record and holds it until the receiver takes it.
  kvd_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_rec   (head_rec),
    .q_pop   (q_pop),
    .tx      (tx)
  );

  // A new result on tx must come from a record that was waiting in the queue.
  a_tx_from_queue: assert property (@(posedge clk) disable iff (rst)
    $rose(tx.valid) |-> $past(q_valid))
    else $error("tx valid rose without a queued record");

  // A protocol error always ends the response.
  a_error_last: assert property (@(posedge clk) disable iff (rst)
    (tx.valid && tx.kind == kvd_pkg::KIND_ERROR) |-> (tx.last && tx.value_count == 32'd0))
    else $error("protocol error result is not marked last or carries a length");

  // Header fields are only shown on header-info results.
  a_header_fields: assert property (@(posedge clk) disable iff (rst)
    (tx.valid && tx.kind != kvd_pkg::KIND_HEADER) |->
      (tx.status_code == 16'd0 && tx.key_count == 16'd0 && tx.extras_count == 8'd0))
    else $error("header fields present on a non-header result");

endmodule

`default_nettype wire
